[sv/ttd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package ttd_pkg;

  // Default sizes of the tree.
  localparam int MaxSideDef   = 32;
  localparam int MaxLevelsDef = 6;
  localparam int ValueBitsDef = 16;

  // Fixed field widths of the ports.
  localparam int CfgW    = 6;
  localparam int ColInW  = 5;
  localparam int ThrW    = 16;
  localparam int OutValW = 16;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_QUERY = 2'd1,
    OP_BIT   = 2'd2
  } opcode_e;

  typedef enum logic [1:0] {
    RS_NEED_BIT = 2'd0,
    RS_DONE     = 2'd1,
    RS_CLEARED  = 2'd2,
    RS_IGNORED  = 2'd3
  } status_e;

  typedef enum logic {
    CFG_GRID_WIDTH  = 1'b0,
    CFG_GRID_HEIGHT = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_INIT  = 3'd0,
    ST_IDLE  = 3'd1,
    ST_CLEAR = 3'd2,
    ST_TABLE = 3'd3,
    ST_ADDR  = 3'd4,
    ST_READ  = 3'd5,
    ST_EVAL  = 3'd6
  } state_e;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [ColInW-1:0] leaf_col;
    logic [ColInW-1:0] leaf_row;
    logic [ThrW-1:0]   threshold;
    logic              coded_bit;
  } item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic               below_threshold;
    logic [OutValW-1:0] leaf_value;
  } result_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    clr_start;
    logic    clr_step;
    logic    tbl_start;
    logic    tbl_step;
    logic    q_load;
    logic    bit_load;
    logic    addr_calc;
    logic    mem_rd;
    logic    eval;
    logic    emit;
    status_e emit_kind;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;
    logic tbl_last;
    logic need_bit;
    logic at_leaf;
  } sts_t;

endpackage

`default_nettype wire

[sv/tag_tree_decoder.sv]
// Tag tree decoder. A query walks one tree level at a time (address, node read, node
// update) from acceptance to its result strobe; a coded bit starts at the node read and
// then walks any further levels the same way. A clear writes one store entry a cycle.
// A new item can be taken in the cycle its predecessor's result is strobed, unless a
// register write holds busy; results cannot stall. After reset the node store is swept
// to zero with busy high; a register write then rebuilds the level table.
`timescale 1ns / 1ps
`default_nettype none

// The block decodes a tag tree over a leaf grid of grid_width by grid_height.
// Every node keeps a value and a progress (its lower bound) in a single
// memory word. A query walks from the root level down to the leaf level and,
// at each level, raises the node to the running bound. While a node is
// unresolved and below the threshold, the block reports that it needs a
// coded bit and waits; the next bit transfer updates that node and the walk
// goes on from there.
//
// The design splits into a controller (ttd_ctrl), which sequences the walk,
// the clearing sweep and the level table build, and a datapath (ttd_dpath),
// which holds the grid registers, the per-level base and span table, the
// query registers, the node store and the result register.
//
// The rate is set by the node store: each level costs an address step,
// one registered read and one read-modify-write, and a coded bit reuses the
// address that the previous pause left behind.
module tag_tree_decoder #(
  parameter int MaxSide   = ttd_pkg::MaxSideDef,
  parameter int MaxLevels = ttd_pkg::MaxLevelsDef,
  parameter int ValueBits = ttd_pkg::ValueBitsDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,

  // Item transfer: taken when start is high and busy is low.
  input  logic                     start,
  input  ttd_pkg::item_t           item_i,
  output logic                     busy,

  // Result transfer: valid for exactly the cycle that done_o is high.
  output logic                     done_o,
  output ttd_pkg::result_t         result_o,

  // Register writes: index 0 is grid_width, index 1 is grid_height.
  input  logic                     cfg_we_i,
  input  logic                     cfg_addr_i,
  input  logic [ttd_pkg::CfgW-1:0] cfg_wdata_i
);

  ttd_pkg::cmd_t cmd;
  ttd_pkg::sts_t sts;

  // The controller decodes the opcode only when an item is offered; the
  // datapath takes the item fields straight from the port.
  ttd_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .opcode_i (item_i.opcode),
    .cfg_we_i (cfg_we_i),
    .sts_i    (sts),
    .cmd_o    (cmd),
    .busy     (busy)
  );

  // Register writes go straight to the datapath; the controller only notes
  // them to cancel the query and rebuild the level table.
  ttd_dpath #(
    .MaxSide   (MaxSide),
    .MaxLevels (MaxLevels),
    .ValueBits (ValueBits)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .item_i      (item_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .done_o      (done_o),
    .result_o    (result_o)
  );

endmodule

`default_nettype wire

[sv/ttd_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module ttd_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  logic [1:0]        opcode_i,
  input  logic              cfg_we_i,
  input  ttd_pkg::sts_t     sts_i,
  output ttd_pkg::cmd_t     cmd_o,
  output logic              busy
);

  ttd_pkg::state_e state_q, state_d;
  logic            active_q, active_d;
  logic            tbl_pend_q, tbl_pend_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ttd_pkg::ST_INIT;
      active_q   <= 1'b0;
      tbl_pend_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      active_q   <= active_d;
      tbl_pend_q <= tbl_pend_d;
    end
  end

  // A register write takes the idle cycle for the table rebuild, so no item
  // is taken in that cycle.
  assign busy = (state_q != ttd_pkg::ST_IDLE) || tbl_pend_q || cfg_we_i;

  // Next state and query bookkeeping.
  always_comb begin
    state_d  = state_q;
    active_d = active_q;
    if (cfg_we_i) begin
      active_d = 1'b0;
    end
    case (state_q)
      ttd_pkg::ST_INIT: begin
        if (sts_i.clr_last) begin
          state_d = (tbl_pend_q || cfg_we_i) ? ttd_pkg::ST_TABLE : ttd_pkg::ST_IDLE;
        end
      end
      ttd_pkg::ST_IDLE: begin
        if (cfg_we_i || tbl_pend_q) begin
          state_d = ttd_pkg::ST_TABLE;
        end else if (start) begin
          case (opcode_i)
            ttd_pkg::OP_CLEAR: begin
              state_d  = ttd_pkg::ST_CLEAR;
              active_d = 1'b0;
            end
            ttd_pkg::OP_QUERY: begin
              state_d  = ttd_pkg::ST_ADDR;
              active_d = 1'b1;
            end
            ttd_pkg::OP_BIT: begin
              if (active_q) begin
                state_d = ttd_pkg::ST_READ;
              end
            end
            default: ;
          endcase
        end
      end
      ttd_pkg::ST_CLEAR: begin
        if (sts_i.clr_last) begin
          state_d = ttd_pkg::ST_IDLE;
        end
      end
      ttd_pkg::ST_TABLE: begin
        if (sts_i.tbl_last) begin
          state_d = ttd_pkg::ST_IDLE;
        end
      end
      ttd_pkg::ST_ADDR: state_d = ttd_pkg::ST_READ;
      ttd_pkg::ST_READ: state_d = ttd_pkg::ST_EVAL;
      ttd_pkg::ST_EVAL: begin
        if (sts_i.need_bit) begin
          state_d = ttd_pkg::ST_IDLE;
        end else if (sts_i.at_leaf) begin
          state_d  = ttd_pkg::ST_IDLE;
          active_d = 1'b0;
        end else begin
          state_d = ttd_pkg::ST_ADDR;
        end
      end
      default: state_d = ttd_pkg::ST_IDLE;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd_o           = '0;
    cmd_o.emit_kind = ttd_pkg::RS_NEED_BIT;
    case (state_q)
      ttd_pkg::ST_INIT: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last && (tbl_pend_q || cfg_we_i)) begin
          cmd_o.tbl_start = 1'b1;
        end
      end
      ttd_pkg::ST_IDLE: begin
        if (cfg_we_i || tbl_pend_q) begin
          cmd_o.tbl_start = 1'b1;
        end else if (start) begin
          case (opcode_i)
            ttd_pkg::OP_CLEAR: cmd_o.clr_start = 1'b1;
            ttd_pkg::OP_QUERY: cmd_o.q_load = 1'b1;
            ttd_pkg::OP_BIT: begin
              if (active_q) begin
                cmd_o.bit_load = 1'b1;
              end else begin
                cmd_o.emit      = 1'b1;
                cmd_o.emit_kind = ttd_pkg::RS_IGNORED;
              end
            end
            default: begin
              cmd_o.emit      = 1'b1;
              cmd_o.emit_kind = ttd_pkg::RS_IGNORED;
            end
          endcase
        end
      end
      ttd_pkg::ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_kind = ttd_pkg::RS_CLEARED;
        end
      end
      ttd_pkg::ST_TABLE: cmd_o.tbl_step = 1'b1;
      ttd_pkg::ST_ADDR:  cmd_o.addr_calc = 1'b1;
      ttd_pkg::ST_READ:  cmd_o.mem_rd = 1'b1;
      ttd_pkg::ST_EVAL: begin
        cmd_o.eval = 1'b1;
        if (sts_i.need_bit) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_kind = ttd_pkg::RS_NEED_BIT;
        end else if (sts_i.at_leaf) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_kind = ttd_pkg::RS_DONE;
        end
      end
      default: ;
    endcase
  end

  assign tbl_pend_d = (tbl_pend_q || cfg_we_i) && !cmd_o.tbl_start;

  // A node is only evaluated on the data that the read stage just fetched.
  a_eval_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ttd_pkg::ST_EVAL) |-> ($past(state_q) == ttd_pkg::ST_READ))
    else $error("evaluation without a preceding node read");

  // A coded bit is applied only to a live query.
  a_bit_needs_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.bit_load |-> active_q)
    else $error("coded bit applied without an active query");

endmodule

`default_nettype wire

[sv/ttd_dpath.sv]
`timescale 1ns / 1ps
`default_nettype none

module ttd_dpath #(
  parameter int MaxSide   = ttd_pkg::MaxSideDef,
  parameter int MaxLevels = ttd_pkg::MaxLevelsDef,
  parameter int ValueBits = ttd_pkg::ValueBitsDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  ttd_pkg::cmd_t            cmd_i,
  output ttd_pkg::sts_t            sts_o,
  input  ttd_pkg::item_t           item_i,
  input  logic                     cfg_we_i,
  input  logic                     cfg_addr_i,
  input  logic [ttd_pkg::CfgW-1:0] cfg_wdata_i,
  output logic                     done_o,
  output ttd_pkg::result_t         result_o
);

  localparam int SideW   = $clog2(MaxSide + 1);
  localparam int ColW    = (MaxSide > 1) ? $clog2(MaxSide) : 1;
  localparam int NodeCap = 2 * MaxSide * MaxSide;
  localparam int IdxW    = $clog2(NodeCap);
  localparam int SumW    = IdxW + 2;
  localparam int LvlW    = $clog2(MaxLevels + 1);
  localparam int TIdxW   = (MaxLevels > 1) ? $clog2(MaxLevels) : 1;
  localparam int SpanXW  = SideW + MaxLevels;
  localparam int ClampW  = SideW + ttd_pkg::CfgW;
  localparam int MulW    = ColW + SideW;
  localparam int WideW   = (ValueBits > ttd_pkg::ThrW) ? ValueBits : ttd_pkg::ThrW;
  localparam int VB      = ValueBits;

  // Grid size and per-level table.
  logic [SideW-1:0] gw_q, gh_q, side_new;
  logic [ClampW-1:0] cfg_x;
  logic [LvlW-1:0]  lvl_cnt_q, tk_q;
  logic [SumW-1:0]  tbase_q;
  logic [SumW-1:0]  base_q  [MaxLevels];
  logic [SideW-1:0] spanw_q [MaxLevels];
  logic [SpanXW-1:0] pow_t, sw_x, sh_x;
  logic [SideW-1:0] sw, sh;
  logic [2*SideW-1:0] prod;
  logic tbl_last;

  // Query registers.
  logic [ColW-1:0]  qcol_q, qrow_q, qcol_new, qrow_new, row_s, col_s;
  logic [ClampW-1:0] col_x, row_x;
  logic [SideW-1:0] gw_m1, gh_m1;
  logic [VB-1:0]    thr_q, bound_q;
  logic [WideW-1:0] thr_x;
  logic [LvlW-1:0]  level_q;
  logic [TIdxW-1:0] lv;
  logic             bit_pend_q, bit_q;

  // Node address and memory.
  logic [MulW-1:0]  rowmul;
  logic [SumW-1:0]  idx_sum;
  logic [IdxW-1:0]  idx_q, clr_cnt_q, mem_waddr;
  logic [2*VB-1:0]  node_mem_q [NodeCap];
  logic [2*VB-1:0]  rd_q, mem_wdata;
  logic             mem_we, clr_last;

  // Node update.
  logic [VB-1:0]    v0, p0, v1, p1, v2, p2, mn;
  logic [WideW-1:0] mn_x;
  logic             raise, need, below, leaf;

  ttd_pkg::result_t result_q;
  logic             done_q;

  // Register writes saturate to the legal side range.
  assign cfg_x = ClampW'(cfg_wdata_i);
  always_comb begin
    if (cfg_x == '0) begin
      side_new = SideW'(1);
    end else if (cfg_x > ClampW'(MaxSide)) begin
      side_new = SideW'(MaxSide);
    end else begin
      side_new = cfg_x[SideW-1:0];
    end
  end

  // Spans of the level under construction: ceil(side / 2^t).
  always_comb begin
    pow_t    = SpanXW'(1) << tk_q;
    sw_x     = (SpanXW'(gw_q) + pow_t - SpanXW'(1)) >> tk_q;
    sh_x     = (SpanXW'(gh_q) + pow_t - SpanXW'(1)) >> tk_q;
    sw       = sw_x[SideW-1:0];
    sh       = sh_x[SideW-1:0];
    prod     = (2*SideW)'(sw) * (2*SideW)'(sh);
    tbl_last = ((sw == SideW'(1)) && (sh == SideW'(1))) ||
               (tk_q == LvlW'(MaxLevels - 1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gw_q      <= SideW'(1);
      gh_q      <= SideW'(1);
      lvl_cnt_q <= LvlW'(1);
      tk_q      <= '0;
      tbase_q   <= '0;
      for (int i = 0; i < MaxLevels; i++) begin
        base_q[i]  <= '0;
        spanw_q[i] <= SideW'(1);
      end
    end else begin
      if (cfg_we_i) begin
        case (cfg_addr_i)
          ttd_pkg::CFG_GRID_WIDTH:  gw_q <= side_new;
          ttd_pkg::CFG_GRID_HEIGHT: gh_q <= side_new;
          default: ;
        endcase
      end
      if (cmd_i.tbl_start) begin
        tk_q    <= '0;
        tbase_q <= '0;
      end else if (cmd_i.tbl_step) begin
        base_q[tk_q[TIdxW-1:0]]  <= tbase_q;
        spanw_q[tk_q[TIdxW-1:0]] <= sw;
        tbase_q <= tbase_q + SumW'(prod);
        tk_q    <= tk_q + LvlW'(1);
        if (tbl_last) begin
          lvl_cnt_q <= tk_q + LvlW'(1);
        end
      end
    end
  end

  // Leaf coordinates saturate to the last column and row.
  always_comb begin
    col_x    = ClampW'(item_i.leaf_col);
    row_x    = ClampW'(item_i.leaf_row);
    gw_m1    = gw_q - SideW'(1);
    gh_m1    = gh_q - SideW'(1);
    qcol_new = (col_x < ClampW'(gw_q)) ? col_x[ColW-1:0] : gw_m1[ColW-1:0];
    qrow_new = (row_x < ClampW'(gh_q)) ? row_x[ColW-1:0] : gh_m1[ColW-1:0];
    thr_x    = WideW'(item_i.threshold);
  end

  // Node address of the current level.
  always_comb begin
    lv      = level_q[TIdxW-1:0];
    row_s   = qrow_q >> level_q;
    col_s   = qcol_q >> level_q;
    rowmul  = MulW'(row_s) * MulW'(spanw_q[lv]);
    idx_sum = base_q[lv] + SumW'(rowmul) + SumW'(col_s);
  end

  // Apply a pending bit, then raise the node to the running bound.
  always_comb begin
    v0    = rd_q[2*VB-1:VB];
    p0    = rd_q[VB-1:0];
    p1    = bit_pend_q ? (p0 + VB'(1)) : p0;
    v1    = (bit_pend_q && !bit_q) ? (v0 + VB'(1)) : v0;
    raise = p1 < bound_q;
    v2    = raise ? bound_q : v1;
    p2    = raise ? bound_q : p1;
    need  = (v2 == p2) && (p2 < thr_q);
    mn    = (v2 < p2) ? v2 : p2;
    below = (v2 < p2) && (v2 < thr_q);
    leaf  = (level_q == '0);
    mn_x  = WideW'(mn);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qcol_q     <= '0;
      qrow_q     <= '0;
      thr_q      <= '0;
      bound_q    <= '0;
      level_q    <= '0;
      bit_pend_q <= 1'b0;
      bit_q      <= 1'b0;
      idx_q      <= '0;
      clr_cnt_q  <= '0;
    end else begin
      if (cmd_i.q_load) begin
        qcol_q     <= qcol_new;
        qrow_q     <= qrow_new;
        thr_q      <= thr_x[VB-1:0];
        bound_q    <= '0;
        level_q    <= lvl_cnt_q - LvlW'(1);
        bit_pend_q <= 1'b0;
      end
      if (cmd_i.bit_load) begin
        bit_pend_q <= 1'b1;
        bit_q      <= item_i.coded_bit;
      end
      if (cmd_i.addr_calc) begin
        idx_q <= (idx_sum < SumW'(NodeCap)) ? idx_sum[IdxW-1:0] : '0;
      end
      if (cmd_i.eval) begin
        bit_pend_q <= 1'b0;
        if (!need) begin
          bound_q <= mn;
          if (!leaf) begin
            level_q <= level_q - LvlW'(1);
          end
        end
      end
      if (cmd_i.clr_start) begin
        clr_cnt_q <= '0;
      end else if (cmd_i.clr_step) begin
        clr_cnt_q <= clr_cnt_q + IdxW'(1);
      end
    end
  end

  assign clr_last  = (clr_cnt_q == IdxW'(NodeCap - 1));
  assign mem_we    = cmd_i.clr_step || cmd_i.eval;
  assign mem_waddr = cmd_i.clr_step ? clr_cnt_q : idx_q;
  assign mem_wdata = cmd_i.clr_step ? '0 : {v2, p2};

  // Node store: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      node_mem_q[mem_waddr] <= mem_wdata;
    end
    if (cmd_i.mem_rd) begin
      rd_q <= node_mem_q[idx_q];
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      result_q.status <= 2'(cmd_i.emit_kind);
      if (cmd_i.emit_kind == ttd_pkg::RS_DONE) begin
        result_q.below_threshold <= below;
        result_q.leaf_value      <= mn_x[ttd_pkg::OutValW-1:0];
      end else begin
        result_q.below_threshold <= 1'b0;
        result_q.leaf_value      <= '0;
      end
    end
  end

  assign done_o   = done_q;
  assign result_o = result_q;

  assign sts_o.clr_last = clr_last;
  assign sts_o.tbl_last = tbl_last;
  assign sts_o.need_bit = need;
  assign sts_o.at_leaf  = leaf;

  // A node written back never has its value above its lower bound.
  a_node_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.eval |-> (v2 <= p2))
    else $error("node value above its progress");

  // The walk never addresses a level beyond the root.
  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.addr_calc |-> (level_q < lvl_cnt_q))
    else $error("walk level outside the tree");

  // A leaf reported below threshold has a final bound below the threshold.
  a_below_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && result_q.below_threshold) |-> (bound_q < thr_q))
    else $error("below_threshold set with bound not below threshold");

endmodule

`default_nettype wire

[verif/tb_tag_tree_decoder.sv]
`timescale 1ns / 1ps

// Self-checking bench for the tag tree decoder.
//
// Items go in through the start/busy command port and every accepted item
// produces exactly one result strobe on done_o. The bench keeps its own
// software copy of the tag tree (node values, node lower bounds, the grid
// registers and the state of the walk in progress). When an item transfer
// completes, that copy is advanced by the item and the result it implies is
// queued. A separate process compares every strobed result with the oldest
// queued one.
//
// Sampling is done on the falling clock edge. Inputs only change right after
// a rising edge and outputs come from registers and those inputs, so busy and done_o
// are stable there and nothing depends on event ordering inside a time step.
module tb_tag_tree_decoder;
  import ttd_pkg::*;

  localparam int          NodeCap   = 2 * MaxSideDef * MaxSideDef;
  localparam int unsigned ThrMask   = (1 << ValueBitsDef) - 1;
  localparam int unsigned CycleCap  = 1_000_000;
  // Opcode three has no name in the package; the block must ignore it.
  localparam logic [1:0]  OpUnused  = 2'd3;

  logic                clk_i;
  logic                rst_ni      = 1'b0;
  logic                start       = 1'b0;
  item_t               item_i      = '0;
  logic                busy;
  logic                done_o;
  result_t             result_o;
  logic                cfg_we_i    = 1'b0;
  logic                cfg_addr_i  = 1'b0;
  logic [CfgW-1:0]     cfg_wdata_i = '0;

  tag_tree_decoder u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .item_i      (item_i),
    .busy        (busy),
    .done_o      (done_o),
    .result_o    (result_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Software copy of the tree. Values are kept 32 bits wide so that a lower
  // bound can never wrap inside the bench.
  int unsigned tree_val [NodeCap];
  int unsigned tree_lb  [NodeCap];
  int unsigned grid_w      = 1;
  int unsigned grid_h      = 1;
  int unsigned n_levels    = 1;
  bit          walking     = 1'b0;
  int unsigned walk_level  = 0;
  int unsigned bound       = 0;
  int unsigned q_col       = 0;
  int unsigned q_row       = 0;
  int unsigned q_thr       = 0;

  result_t     pending_results [$];
  int unsigned mismatches = 0;

  // Sender pacing: bursts of back-to-back items separated by random gaps.
  // While steady is set the sender never pauses.
  int unsigned burst_left = 0;
  bit          steady     = 1'b0;

  initial begin
    foreach (tree_val[i]) begin
      tree_val[i] = 0;
      tree_lb[i]  = 0;
    end
  end

  // Number of nodes along one side at level t (ceiling division by 2^t).
  function automatic int unsigned span(int unsigned side, int unsigned t);
    return (side + (1 << t) - 1) >> t;
  endfunction

  // The root level is reached once both sides shrink to one node, but the
  // tree never grows beyond MaxLevelsDef levels.
  function automatic void recount_levels();
    int unsigned w, h, n;
    w = grid_w;
    h = grid_h;
    n = 1;
    while ((w != 1 || h != 1) && n < MaxLevelsDef) begin
      w = (w + 1) >> 1;
      h = (h + 1) >> 1;
      n++;
    end
    n_levels = n;
  endfunction

  // Levels are stored one after the other, leaf level first, row-major.
  function automatic int unsigned tree_node(int unsigned t);
    int unsigned base, idx, k;
    base = 0;
    for (k = 0; k < t; k++) base += span(grid_w, k) * span(grid_h, k);
    idx = base + (q_row >> t) * span(grid_w, t) + (q_col >> t);
    return (idx < NodeCap) ? idx : 0;
  endfunction

  // Walk down from the current level until a node needs another coded bit
  // or the leaf has been settled.
  function automatic result_t descend();
    result_t     r;
    int unsigned idx;
    r = '0;
    while (1'b1) begin
      idx = tree_node(walk_level);
      if (tree_lb[idx] < bound) begin
        tree_lb[idx]  = bound;
        tree_val[idx] = bound;
      end
      if (tree_val[idx] == tree_lb[idx] && tree_lb[idx] < q_thr) begin
        r.status = RS_NEED_BIT;
        return r;
      end
      bound = (tree_val[idx] < tree_lb[idx]) ? tree_val[idx] : tree_lb[idx];
      if (walk_level == 0) break;
      walk_level--;
    end
    walking           = 1'b0;
    r.status          = RS_DONE;
    r.below_threshold = (tree_val[idx] < tree_lb[idx]) && (tree_val[idx] < q_thr);
    r.leaf_value      = bound[OutValW-1:0];
    return r;
  endfunction

  // Advance the tree copy by one accepted item and return its result.
  function automatic result_t decode_item(item_t it);
    result_t     r;
    int unsigned idx;
    r = '0;
    r.status = RS_IGNORED;
    case (it.opcode)
      OP_CLEAR: begin
        foreach (tree_val[i]) begin
          tree_val[i] = 0;
          tree_lb[i]  = 0;
        end
        walking  = 1'b0;
        r.status = RS_CLEARED;
      end
      OP_QUERY: begin
        // Leaves outside the grid land on the last column or row.
        q_col      = (it.leaf_col < grid_w) ? it.leaf_col : grid_w - 1;
        q_row      = (it.leaf_row < grid_h) ? it.leaf_row : grid_h - 1;
        q_thr      = it.threshold & ThrMask;
        walk_level = n_levels - 1;
        bound      = 0;
        walking    = 1'b1;
        r          = descend();
      end
      OP_BIT: begin
        // A 1 bit settles the node, a 0 bit pushes its value up with the bound.
        if (walking) begin
          idx = tree_node(walk_level);
          tree_lb[idx]++;
          if (!it.coded_bit) tree_val[idx]++;
          r = descend();
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // A register write saturates the side, rebuilds the level count and drops
  // any walk in progress; the node store is left alone.
  function automatic void apply_reg(cfg_idx_e which, logic [CfgW-1:0] v);
    int unsigned side;
    side = (v < 1) ? 1 : ((v > MaxSideDef) ? MaxSideDef : 32'(v));
    if (which == CFG_GRID_WIDTH) grid_w = side;
    else grid_h = side;
    recount_levels();
    walking = 1'b0;
  endfunction

  function automatic void flag(string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endfunction

  // Result checking. done_o is high for exactly one cycle, so looking at it
  // on the falling edge sees each result transfer once.
  always @(negedge clk_i) begin
    if (rst_ni && done_o === 1'b1) begin
      if (pending_results.size() == 0) begin
        flag($sformatf("unexpected result: status=%0d below=%0d value=%0d",
                       result_o.status, result_o.below_threshold,
                       result_o.leaf_value));
      end else if (result_o.status !== pending_results[0].status ||
                   result_o.below_threshold !== pending_results[0].below_threshold ||
                   result_o.leaf_value !== pending_results[0].leaf_value) begin
        flag($sformatf("result mismatch: want status=%0d below=%0d value=%0d, got %0d %0d %0d",
                       pending_results[0].status, pending_results[0].below_threshold,
                       pending_results[0].leaf_value, result_o.status,
                       result_o.below_threshold, result_o.leaf_value));
        void'(pending_results.pop_front());
      end else begin
        void'(pending_results.pop_front());
      end
    end
  end

  // Called right after the rising edge that completed a transfer.
  task automatic pace();
    if (steady) return;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = $urandom_range(1, 16);
    end
  endtask

  // Present one item and hold it until the transfer happens. Called just
  // after a rising edge; the item is taken at the first rising edge that
  // follows a falling edge with busy low.
  task automatic send_item(item_t it);
    bit taken;
    taken = 1'b0;
    start  <= 1'b1;
    item_i <= it;
    while (!taken) begin
      @(negedge clk_i);
      taken = !busy;
      @(posedge clk_i);
    end
    pending_results.push_back(decode_item(it));
    pace();
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Registers are only written with nothing in flight and busy low, which
  // also covers the clearing sweep after reset and the table rebuild that a
  // previous write starts.
  task automatic write_reg(cfg_idx_e which, logic [CfgW-1:0] v);
    do @(negedge clk_i); while (busy || pending_results.size() != 0);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= which;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    apply_reg(which, v);
  endtask

  task automatic set_grid(logic [CfgW-1:0] w, logic [CfgW-1:0] h);
    if ($urandom_range(0, 1)) begin
      write_reg(CFG_GRID_WIDTH, w);
      write_reg(CFG_GRID_HEIGHT, h);
    end else begin
      write_reg(CFG_GRID_HEIGHT, h);
      write_reg(CFG_GRID_WIDTH, w);
    end
  endtask

  // Every field is set whatever the opcode; rand_item fills the unused ones at random.
  function automatic item_t make_item(logic [1:0] op, int unsigned col, int unsigned row,
                                      int unsigned thr, bit b);
    item_t it;
    it.opcode    = op;
    it.leaf_col  = col[ColInW-1:0];
    it.leaf_row  = row[ColInW-1:0];
    it.threshold = thr[ThrW-1:0];
    it.coded_bit = b;
    return it;
  endfunction

  function automatic item_t rand_item(logic [1:0] op);
    return make_item(op, $urandom_range(0, 31), $urandom_range(0, 31),
                     $urandom_range(0, 65535), 1'($urandom_range(0, 1)));
  endfunction

  // Mostly small thresholds so that walks end after a few bits; now and
  // then the full range, which usually ends on a 1 bit or gets abandoned.
  function automatic int unsigned pick_threshold();
    if ($urandom_range(0, 99) < 85) return $urandom_range(0, 6);
    return $urandom_range(0, 65535);
  endfunction

  task automatic finish_query(bit b);
    while (walking) send_item(make_item(OP_BIT, $urandom_range(0, 31),
                                        $urandom_range(0, 31), $urandom, b));
  endtask

  // Reset grid of a single leaf: ignored items, thresholds at both ends,
  // an already settled node, a threshold reached by 0 bits, and walks that
  // are abandoned by a new query or by a clear.
  task automatic test_default_grid();
    send_item(rand_item(OP_BIT));
    send_item(rand_item(OpUnused));
    send_item(make_item(OP_QUERY, 0, 0, 0, 1'b0));
    send_item(make_item(OP_QUERY, 31, 31, 65535, 1'b0));
    send_item(make_item(OP_BIT, 0, 0, 0, 1'b1));
    send_item(make_item(OP_QUERY, 0, 0, 3, 1'b0));
    send_item(rand_item(OP_CLEAR));
    send_item(make_item(OP_QUERY, 0, 0, 2, 1'b1));
    finish_query(1'b0);
    send_item(make_item(OP_QUERY, 0, 0, 5, 1'b0));
    send_item(make_item(OP_QUERY, 0, 0, 4, 1'b0));
    send_item(rand_item(OP_CLEAR));
    send_item(rand_item(OP_BIT));
    wait_drained();
  endtask

  // Saturating register values, a write that cancels a pending walk, and
  // full-depth walks on the largest grid.
  task automatic test_grid_registers();
    set_grid(6'h3f, 6'h00);
    send_item(make_item(OP_QUERY, 31, 9, 1, 1'b0));
    wait_drained();
    write_reg(CFG_GRID_HEIGHT, 6'h00);
    send_item(rand_item(OP_BIT));
    wait_drained();
    set_grid(6'h20, 6'h21);
    send_item(make_item(OP_QUERY, 31, 31, 1, 1'b0));
    finish_query(1'b1);
    send_item(make_item(OP_QUERY, 0, 0, 3, 1'b0));
    finish_query(1'b0);
    wait_drained();
  endtask

  // Random traffic. While a walk is open most items are coded bits, so walks
  // run to the leaf; the rest abandons them, clears the tree or is noise.
  task automatic run_traffic(int unsigned n_items);
    item_t       it;
    int unsigned counted, pick;
    counted = 0;
    while (counted < n_items) begin
      pick = $urandom_range(0, 99);
      if (walking) begin
        if (pick < 86) begin
          it = rand_item(OP_BIT);
          it.coded_bit = ($urandom_range(0, 99) < 35);
        end else if (pick < 94) begin
          it = rand_item(OP_QUERY);
          it.threshold = ThrW'(pick_threshold());
        end else if (pick < 96) begin
          it = rand_item(OP_CLEAR);
        end else begin
          it = rand_item(OpUnused);
        end
      end else begin
        if (pick < 84) begin
          it = rand_item(OP_QUERY);
          it.threshold = ThrW'(pick_threshold());
        end else if (pick < 91) begin
          it = rand_item(OP_BIT);
        end else if (pick < 97) begin
          it = rand_item(OpUnused);
        end else begin
          it = rand_item(OP_CLEAR);
        end
      end
      if (!(it.opcode == OpUnused || (it.opcode == OP_BIT && !walking))) counted++;
      send_item(it);
    end
    wait_drained();
  endtask

  // Several grid shapes, the extremes first, then random register values
  // (out-of-range codes included). Every third phase runs without gaps.
  task automatic test_random_grids();
    int unsigned phase;
    for (phase = 0; phase < 8; phase++) begin
      case (phase)
        0: set_grid(6'h3f, 6'h3f);
        1: set_grid(6'h00, 6'h00);
        2: set_grid(6'h01, 6'h20);
        3: set_grid(6'h20, 6'h01);
        default: set_grid(6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)));
      endcase
      steady = (phase % 3 == 2);
      run_traffic(150);
    end
    steady = 1'b0;
  endtask

  // Watchdog: a run that hangs is reported broken.
  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < CycleCap) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_default_grid();
    test_grid_registers();
    test_random_grids();

    // Let any stray strobe show up before judging the run.
    repeat (64) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      flag($sformatf("%0d results never arrived", pending_results.size()));
    end
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
